// ===== hw/rtl/cst_pkg.sv =====
// Shared types and constants for the CSV stream tokenizer.
package cst_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] ChSep   = 8'h2C;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;

  typedef enum logic [2:0] {
    MODE_NEW  = 3'd0,
    MODE_UNQ  = 3'd1,
    MODE_QUO  = 3'd2,
    MODE_QQ   = 3'd3,
    MODE_SKIP = 3'd4
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_DROP  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_file;
  } item_t;

  typedef struct packed {
    logic             emit;
    kind_e            kind;
    logic [ByteW-1:0] out_byte;
  } token_t;

endpackage

// ===== hw/rtl/cst_in_stage.sv =====
// Input register stage of the tokenizer.
module cst_in_stage
  import cst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign ready_o = !valid_q || advance_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/cst_step.sv =====
// Parse mode state machine: one character or end-of-file mark per step.
module cst_step
  import cst_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  item_t  item_i,
  input  logic   advance_i,
  output token_t token_o
);

  mode_e mode_q, mode_d;
  logic  sep_q, sep_d;
  logic  eof, line_end, is_quote, is_sep;

  assign eof      = item_i.end_of_file;
  assign line_end = !eof && (item_i.in_byte == ChCr || item_i.in_byte == ChLf);
  assign is_quote = !eof && (item_i.in_byte == ChQuote);
  assign is_sep   = !eof && (item_i.in_byte == ChSep);

  // Next mode and separator flag.
  always_comb begin
    mode_d = mode_q;
    sep_d  = sep_q;
    unique case (mode_q)
      MODE_UNQ: begin
        if (eof || line_end) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b0;
        end else if (is_sep) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b1;
        end
      end
      MODE_QUO: begin
        if (eof) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b0;
        end else if (is_quote) begin
          mode_d = MODE_QQ;
        end
      end
      MODE_QQ: begin
        if (eof || line_end) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b0;
        end else if (is_quote) begin
          mode_d = MODE_QUO;
        end else if (is_sep) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b1;
        end else begin
          mode_d = MODE_SKIP;
          sep_d  = 1'b0;
        end
      end
      MODE_SKIP: begin
        if (eof || line_end) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b0;
        end
      end
      default: begin
        // New entry; unreachable codes behave the same way.
        if (eof || line_end) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b0;
        end else if (is_quote) begin
          mode_d = MODE_QUO;
        end else if (is_sep) begin
          mode_d = MODE_NEW;
          sep_d  = 1'b1;
        end else begin
          mode_d = MODE_UNQ;
        end
      end
    endcase
  end

  // Token produced by this step.
  always_comb begin
    token_o.emit     = 1'b0;
    token_o.kind     = KIND_BYTE;
    token_o.out_byte = '0;
    unique case (mode_q)
      MODE_UNQ: begin
        token_o.emit = 1'b1;
        if (eof || line_end) begin
          token_o.kind = KIND_LINE;
        end else if (is_sep) begin
          token_o.kind = KIND_FIELD;
        end else begin
          token_o.out_byte = item_i.in_byte;
        end
      end
      MODE_QUO: begin
        if (eof) begin
          token_o.emit = 1'b1;
          token_o.kind = KIND_DROP;
        end else if (!is_quote) begin
          token_o.emit     = 1'b1;
          token_o.out_byte = item_i.in_byte;
        end
      end
      MODE_QQ: begin
        token_o.emit = 1'b1;
        if (eof || line_end) begin
          token_o.kind = KIND_LINE;
        end else if (is_quote) begin
          token_o.out_byte = ChQuote;
        end else if (is_sep) begin
          token_o.kind = KIND_FIELD;
        end else begin
          token_o.kind = KIND_DROP;
        end
      end
      MODE_SKIP: begin
        token_o.emit = 1'b0;
      end
      default: begin
        if (eof || line_end) begin
          token_o.emit = sep_q;
          token_o.kind = KIND_LINE;
        end else if (is_sep) begin
          token_o.emit = 1'b1;
          token_o.kind = KIND_FIELD;
        end else if (!is_quote) begin
          token_o.emit     = 1'b1;
          token_o.out_byte = item_i.in_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NEW;
      sep_q  <= 1'b0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      sep_q  <= sep_d;
    end
  end

endmodule

// ===== hw/rtl/cst_out_stage.sv =====
// Result register stage of the tokenizer.
module cst_out_stage
  import cst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  token_t           token_i,
  input  logic             ready_i,
  output logic             valid_o,
  output kind_e            kind_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  kind_e            kind_q;
  logic [ByteW-1:0] byte_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= token_i.kind;
      byte_q <= token_i.out_byte;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign byte_o  = byte_q;

endmodule

// ===== hw/rtl/csv_stream_tokenizer_unit.sv =====
// Top level of the CSV stream tokenizer.
//
// Channel  Direction  tdata           tuser
// s_axis   in         [7:0] in_byte   [0] end_of_file
// m_axis   out        [7:0] out_byte  [1:0] token_kind
//
// Each s_axis transfer, a character or an end-of-file mark, yields at most one
// m_axis token. The item is registered on entry in the input register and is
// parsed into the result register once that register has room for its token,
// if any, which is then valid on m_axis. One item per cycle is sustained while
// m_axis does not stall. A stalled m_axis holds its token and then the input
// register; items that produce no token still move on. Reset clears both valid
// flags and returns to new entry.
module csv_stream_tokenizer_unit
  import cst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic             s_axis_tuser_i,  // [0] end_of_file
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [ByteW-1:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [KindW-1:0] m_axis_tuser_o   // [1:0] token_kind
);

  item_t  in_item;
  item_t  held_item;
  logic   held_valid;
  token_t token;
  logic   advance;
  logic   out_valid;
  kind_e  out_kind;

  assign in_item.in_byte     = s_axis_tdata_i;
  assign in_item.end_of_file = s_axis_tuser_i;

  // The held item is parsed when its token, if any, has room in the result
  // register: that register is empty or is being emptied in this cycle.
  assign advance = held_valid && (!token.emit || !out_valid || m_axis_tready_i);

  cst_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  cst_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (held_item),
    .advance_i (advance),
    .token_o   (token)
  );

  cst_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && token.emit),
    .token_i (token),
    .ready_i (m_axis_tready_i),
    .valid_o (out_valid),
    .kind_o  (out_kind),
    .byte_o  (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tuser_o  = out_kind;

endmodule
